@@ rtl/pidsl_pkg.sv @@
// ----------------------------------------------------------------------------
// pidsl_pkg: shared types and constants of the PID controller
// Field widths, register indexes, serial unit widths and fixed divisors.
// ----------------------------------------------------------------------------
package pidsl_pkg;

  // default sizing of the integral accumulator
  localparam int INTEGRAL_BITS_DEF = 48;
  localparam int FRAC_BITS_DEF     = 16;

  // item and register field widths
  localparam int POS_W      = 16;
  localparam int DT_W       = 16;
  localparam int GAIN_W     = 24;
  localparam int OLIM_W     = 15;
  localparam int SLEW_W     = 16;
  localparam int ILIM_W     = 31;
  localparam int DRIVE_W    = 24;
  localparam int ERR_W      = 18;
  localparam int SLOPE_W    = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT  = 3'd5;

  // serial arithmetic unit widths: dividend/multiplicand, divisor/multiplier, product
  localparam int ALU_A_W = 64;
  localparam int ALU_B_W = 24;
  localparam int ALU_P_W = ALU_A_W + ALU_B_W;

  // fixed divisors and rounding offsets
  localparam int DIV_MS       = 1000;
  localparam int HALF_MS      = 500;
  localparam int DECAY_DIV    = 10;
  localparam int DECAY_HALF   = 5;
  localparam int SLOPE_DIV    = 5;
  localparam int SLOPE_HALF   = 2;
  localparam int ITERM_CAP_LG = 60;

  typedef enum logic {ALU_MUL, ALU_DIV} alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

endpackage

@@ rtl/pidsl_serial_alu.sv @@
// ----------------------------------------------------------------------------
// pidsl_serial_alu: bit-serial multiplier and restoring divider
// One multiplier bit or one quotient bit per cycle, shared by all steps.
// ----------------------------------------------------------------------------
module pidsl_serial_alu
  import pidsl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  alu_cmd_t           cmd,
  input  logic [ALU_A_W-1:0] opa,
  input  logic [ALU_B_W-1:0] opb,
  output logic               busy,
  output logic [ALU_P_W-1:0] res
);

  localparam int CNT_W = $clog2(ALU_A_W + 1);

  logic               busy_r, busy_nxt;
  alu_op_t            op_r, op_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ALU_P_W-1:0] acc_r, acc_nxt;
  logic [ALU_P_W-1:0] sh_r, sh_nxt;
  logic [ALU_B_W-1:0] b_r, b_nxt;
  logic [ALU_B_W-1:0] rem_r, rem_nxt;
  logic [ALU_B_W:0]   rem_sh, rem_diff;
  logic               rem_ge;

  // partial remainder with next dividend bit shifted in
  assign rem_sh   = {rem_r, sh_r[ALU_A_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, b_r};
  assign rem_diff = rem_sh - {1'b0, b_r};

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd.op;
      acc_nxt  = '0;
      sh_nxt   = ALU_P_W'(opa);
      b_nxt    = opb;
      rem_nxt  = '0;
      cnt_nxt  = (cmd.op == ALU_MUL) ? CNT_W'(ALU_B_W) : CNT_W'(ALU_A_W);
    end else if (busy_r) begin
      case (op_r)
        ALU_MUL: begin
          // shift-add, multiplier LSB first
          if (b_r[0]) begin
            acc_nxt = acc_r + sh_r;
          end
          sh_nxt = sh_r << 1;
          b_nxt  = b_r >> 1;
        end
        ALU_DIV: begin
          // restoring step, quotient bits shift in at the bottom
          rem_nxt = rem_ge ? rem_diff[ALU_B_W-1:0] : rem_sh[ALU_B_W-1:0];
          sh_nxt  = {sh_r[ALU_P_W-2:0], rem_ge};
        end
        default: begin
          sh_nxt = sh_r;
        end
      endcase
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      op_r   <= ALU_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign res  = (op_r == ALU_MUL) ? acc_r : ALU_P_W'(sh_r[ALU_A_W-1:0]);

endmodule

@@ rtl/pid_antiwindup_slew_limited_unit.sv @@
// ----------------------------------------------------------------------------
// pid_antiwindup_slew_limited_unit: PID position controller
// Clamped integral with decay, filtered derivative, output clamp and slew.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_valid/in_ready) carry setpoint, measured, elapsed_ms and
//   restart. Each item gives one drive item on out_valid/out_ready.
//   Gains and limits are written on the cfg_we/cfg_index/cfg_wdata port;
//   the user must write them only while the block is idle (not enforced).
//   One item at a time: a new item is taken only once the previous one has
//   left the sequencer. All arithmetic runs through one bit-serial unit:
//   five multiplies and three to five divides per update. The divides are
//   the integral increment, decay, derivative, filter and slew step. A
//   first update after reset or restart skips the arithmetic and goes
//   straight to S_OUT, which sends 0 once the output register is free.
//   The result sits in an output register, so the next item can be accepted
//   while it waits; if the receiver stalls, the following result holds in
//   the sequencer until the register frees up.
//   Reset (synchronous, active low) clears configuration registers and controller state;
//   the next item is then a first update.
// ----------------------------------------------------------------------------
module pid_antiwindup_slew_limited_unit
  import pidsl_pkg::*;
#(
  parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [POS_W-1:0]   in_setpoint,
  input  logic signed [POS_W-1:0]   in_measured,
  input  logic [DT_W-1:0]           in_elapsed_ms,
  input  logic                      in_restart,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DRIVE_W-1:0] out_drive
);

  localparam int IB     = INTEGRAL_BITS;
  localparam int ISUM_W = 66;
  localparam int INC_W  = 48;
  localparam int PMAG_W = GAIN_W + 17;
  localparam int IMAG_W = ITERM_CAP_LG + 1;
  localparam int X_W    = SLOPE_W + 2;
  localparam int SUM_W  = 63;
  localparam int DMAG_W = 57;
  localparam int SLW_W  = DRIVE_W + 9;

  localparam logic [ISUM_W-1:0] IMAX =
    {{(ISUM_W - IB + 1){1'b0}}, {(IB - 1){1'b1}}};
  localparam logic [ISUM_W-1:0] IMIN = ~IMAX;
  localparam logic [ALU_P_W-1:0] ITERM_CAP = ALU_P_W'(1) << ITERM_CAP_LG;
  localparam logic [ALU_P_W-1:0] IHALF = ALU_P_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_P, S_ED, S_INC, S_INTEG, S_DECAY, S_IMUL, S_RAW,
    S_SLOPE, S_DMUL, S_SUM, S_CLAMP, S_STEP, S_SLEW, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [OLIM_W-1:0] olim_r;
  logic [SLEW_W-1:0] slew_r;
  logic [ILIM_W-1:0] ilim_r;

  // controller state
  logic               armed_r, armed_nxt;
  logic [IB-1:0]      integ_r, integ_nxt;
  logic [ERR_W-1:0]   last_err_r, last_err_nxt;
  logic [SLOPE_W-1:0] slope_r, slope_nxt;
  logic [DRIVE_W-1:0] last_drive_r, last_drive_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DRIVE_W-1:0] out_drive_r, out_drive_nxt;

  // per-item working registers
  logic [DT_W-1:0]    dt_r, dt_nxt;
  logic [ERR_W-1:0]   err_r, err_nxt;
  logic [PMAG_W-1:0]  p_mag_r, p_mag_nxt;
  logic [IMAG_W-1:0]  imag_r, imag_nxt;
  logic               x_neg_r, x_neg_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [DRIVE_W-1:0] o_r, o_nxt;
  logic [DRIVE_W-1:0] res_r, res_nxt;

  // serial unit
  alu_cmd_t           alu_cmd;
  logic [ALU_A_W-1:0] alu_a;
  logic [ALU_B_W-1:0] alu_b;
  logic               alu_busy;
  logic [ALU_P_W-1:0] alu_res;

  pidsl_serial_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (alu_cmd),
    .opa   (alu_a),
    .opb   (alu_b),
    .busy  (alu_busy),
    .res   (alu_res)
  );

  // error magnitude and sign
  logic              err_neg;
  logic [ERR_W-1:0]  err_abs;
  logic [16:0]       err_mag;
  assign err_neg = err_r[ERR_W-1];
  assign err_abs = err_neg ? -err_r : err_r;
  assign err_mag = err_abs[16:0];

  // integral update: saturating add, then clamp when gain_i is set
  logic [INC_W-1:0]  inc_mag;
  logic [ISUM_W-1:0] inc_u, inc_v, integ_x, isum, isat, il, il_n, iclamp;
  logic [IB-1:0]     ival, ival_mag, integ_mag, decay_mag;
  logic              decay_req;
  assign inc_mag  = alu_res[INC_W-1:0];
  assign inc_u    = ISUM_W'(inc_mag);
  assign inc_v    = err_neg ? -inc_u : inc_u;
  assign integ_x  = {{(ISUM_W - IB){integ_r[IB-1]}}, integ_r};
  assign isum     = integ_x + inc_v;
  assign isat     = ($signed(isum) > $signed(IMAX)) ? IMAX :
                    (($signed(isum) < $signed(IMIN)) ? IMIN : isum);
  assign il       = ISUM_W'(ilim_r) << FRAC_BITS;
  assign il_n     = -il;
  assign iclamp   = (gain_i_r == '0) ? isat :
                    (($signed(isat) > $signed(il)) ? il :
                     (($signed(isat) < $signed(il_n)) ? il_n : isat));
  assign ival     = iclamp[IB-1:0];
  assign ival_mag = ival[IB-1] ? -ival : ival;
  assign decay_req = (gain_i_r != '0) && (p_mag_r > (PMAG_W'(olim_r) << 16));
  assign integ_mag = integ_r[IB-1] ? -integ_r : integ_r;
  assign decay_mag = integ_mag - alu_res[IB-1:0];

  // integral term, rounded and capped
  logic [ALU_P_W-1:0] iround, ishift;
  logic [IMAG_W-1:0]  imag_v;
  assign iround = alu_res + IHALF;
  assign ishift = iround >> FRAC_BITS;
  assign imag_v = (ishift > ITERM_CAP) ? ITERM_CAP[IMAG_W-1:0] : ishift[IMAG_W-1:0];

  // derivative numerator: |de| * 256000 + dt/2
  logic [ERR_W:0]     de_v, de_abs;
  logic               de_neg;
  logic [ERR_W-1:0]   de_mag;
  logic [27:0]        de_k;
  logic [ALU_A_W-1:0] raw_num;
  assign de_v    = {err_r[ERR_W-1], err_r} - {last_err_r[ERR_W-1], last_err_r};
  assign de_neg  = de_v[ERR_W];
  assign de_abs  = de_neg ? -de_v : de_v;
  assign de_mag  = de_abs[ERR_W-1:0];
  assign de_k    = (28'(de_mag) << 10) - (28'(de_mag) << 4) - (28'(de_mag) << 3);
  assign raw_num = (ALU_A_W'(de_k) << 8) + ALU_A_W'(dt_r >> 1);

  // low-pass input: 4*raw + old slope
  logic [35:0]    raw_mag;
  logic [X_W-1:0] raw_u, raw_v, x_v, x_abs;
  logic           x_neg_v;
  assign raw_mag = (dt_r != '0) ? alu_res[35:0] : '0;
  assign raw_u   = X_W'(raw_mag);
  assign raw_v   = de_neg ? -raw_u : raw_u;
  assign x_v     = (raw_v << 2) + {{(X_W - SLOPE_W){slope_r[SLOPE_W-1]}}, slope_r};
  assign x_neg_v = x_v[X_W-1];
  assign x_abs   = x_neg_v ? -x_v : x_v;

  logic [SLOPE_W-1:0] slope_q;
  assign slope_q = alu_res[SLOPE_W-1:0];

  // term sum
  logic [64:0]       dsum;
  logic [DMAG_W-1:0] d_mag;
  logic [SUM_W-1:0]  d_u, d_v, p_u, p_v, i_u, i_v;
  assign dsum  = {1'b0, alu_res[63:0]} + 65'd128;
  assign d_mag = dsum[64:8];
  assign d_u   = SUM_W'(d_mag);
  assign d_v   = slope_r[SLOPE_W-1] ? -d_u : d_u;
  assign p_u   = SUM_W'(p_mag_r);
  assign p_v   = err_neg ? -p_u : p_u;
  assign i_u   = SUM_W'(imag_r);
  assign i_v   = integ_r[IB-1] ? -i_u : i_u;

  // output clamp and Q15.8 rounding
  logic [SUM_W-1:0]   lim_s, lim_n, c_v, c_abs;
  logic               c_neg;
  logic [31:0]        c_rnd;
  logic [DRIVE_W-1:0] o_mag;
  assign lim_s = SUM_W'(olim_r) << 16;
  assign lim_n = -lim_s;
  assign c_v   = ($signed(sum_r) > $signed(lim_s)) ? lim_s :
                 (($signed(sum_r) < $signed(lim_n)) ? lim_n : sum_r);
  assign c_neg = c_v[SUM_W-1];
  assign c_abs = c_neg ? -c_v : c_v;
  assign c_rnd = c_abs[31:0] + 32'd128;
  assign o_mag = c_rnd[31:8];

  // slew limit
  logic [SLW_W-1:0] step_v, step_n, chg, last_x, up_v, dn_v;
  assign step_v = SLW_W'(alu_res[30:0]);
  assign step_n = -step_v;
  assign last_x = {{(SLW_W - DRIVE_W){last_drive_r[DRIVE_W-1]}}, last_drive_r};
  assign chg    = {{(SLW_W - DRIVE_W){o_r[DRIVE_W-1]}}, o_r} - last_x;
  assign up_v   = last_x + step_v;
  assign dn_v   = last_x - step_v;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    armed_nxt      = armed_r;
    integ_nxt      = integ_r;
    last_err_nxt   = last_err_r;
    slope_nxt      = slope_r;
    last_drive_nxt = last_drive_r;
    out_valid_nxt  = out_valid_r;
    out_drive_nxt  = out_drive_r;
    dt_nxt         = dt_r;
    err_nxt        = err_r;
    p_mag_nxt      = p_mag_r;
    imag_nxt       = imag_r;
    x_neg_nxt      = x_neg_r;
    sum_nxt        = sum_r;
    o_nxt          = o_r;
    res_nxt        = res_r;
    alu_cmd        = '{start: 1'b0, op: ALU_MUL};
    alu_a          = '0;
    alu_b          = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dt_nxt  = in_elapsed_ms;
          err_nxt = {{2{in_setpoint[POS_W-1]}}, in_setpoint}
                  - {{2{in_measured[POS_W-1]}}, in_measured};
          if (in_restart || !armed_r) begin
            // first update: arm and answer zero
            integ_nxt      = '0;
            last_err_nxt   = '0;
            slope_nxt      = '0;
            last_drive_nxt = '0;
            armed_nxt      = 1'b1;
            res_nxt        = '0;
            state_nxt      = S_OUT;
          end else begin
            state_nxt = S_P;
          end
        end
      end
      S_P: begin
        alu_cmd   = '{start: 1'b1, op: ALU_MUL};
        alu_a     = ALU_A_W'(err_mag);
        alu_b     = gain_p_r;
        state_nxt = S_ED;
      end
      S_ED: begin
        if (!alu_busy) begin
          p_mag_nxt = alu_res[PMAG_W-1:0];
          alu_cmd   = '{start: 1'b1, op: ALU_MUL};
          alu_a     = ALU_A_W'(err_mag);
          alu_b     = ALU_B_W'(dt_r);
          state_nxt = S_INC;
        end
      end
      S_INC: begin
        // integral increment: |err|*dt*2^F / 1000, rounded
        if (!alu_busy) begin
          alu_cmd   = '{start: 1'b1, op: ALU_DIV};
          alu_a     = (ALU_A_W'(alu_res[32:0]) << FRAC_BITS) + ALU_A_W'(HALF_MS);
          alu_b     = ALU_B_W'(DIV_MS);
          state_nxt = S_INTEG;
        end
      end
      S_INTEG: begin
        if (!alu_busy) begin
          integ_nxt = ival;
          if (decay_req) begin
            alu_cmd   = '{start: 1'b1, op: ALU_DIV};
            alu_a     = ALU_A_W'(ival_mag) + ALU_A_W'(DECAY_HALF);
            alu_b     = ALU_B_W'(DECAY_DIV);
            state_nxt = S_DECAY;
          end else begin
            state_nxt = S_IMUL;
          end
        end
      end
      S_DECAY: begin
        // magnitude shrinks by a rounded tenth
        if (!alu_busy) begin
          integ_nxt = integ_r[IB-1] ? -decay_mag : decay_mag;
          state_nxt = S_IMUL;
        end
      end
      S_IMUL: begin
        alu_cmd   = '{start: 1'b1, op: ALU_MUL};
        alu_a     = ALU_A_W'(integ_mag);
        alu_b     = gain_i_r;
        state_nxt = S_RAW;
      end
      S_RAW: begin
        if (!alu_busy) begin
          imag_nxt = imag_v;
          if (dt_r != '0) begin
            alu_cmd = '{start: 1'b1, op: ALU_DIV};
            alu_a   = raw_num;
            alu_b   = ALU_B_W'(dt_r);
          end
          state_nxt = S_SLOPE;
        end
      end
      S_SLOPE: begin
        if (!alu_busy) begin
          x_neg_nxt = x_neg_v;
          alu_cmd   = '{start: 1'b1, op: ALU_DIV};
          alu_a     = ALU_A_W'(x_abs) + ALU_A_W'(SLOPE_HALF);
          alu_b     = ALU_B_W'(SLOPE_DIV);
          state_nxt = S_DMUL;
        end
      end
      S_DMUL: begin
        if (!alu_busy) begin
          slope_nxt = x_neg_r ? -slope_q : slope_q;
          alu_cmd   = '{start: 1'b1, op: ALU_MUL};
          alu_a     = ALU_A_W'(slope_q);
          alu_b     = gain_d_r;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (!alu_busy) begin
          sum_nxt   = p_v + i_v + d_v;
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        o_nxt     = c_neg ? -o_mag : o_mag;
        alu_cmd   = '{start: 1'b1, op: ALU_MUL};
        alu_a     = ALU_A_W'(slew_r);
        alu_b     = ALU_B_W'(dt_r);
        state_nxt = S_STEP;
      end
      S_STEP: begin
        // largest step: slew*dt*256 / 1000, rounded
        if (!alu_busy) begin
          alu_cmd   = '{start: 1'b1, op: ALU_DIV};
          alu_a     = (ALU_A_W'(alu_res[31:0]) << 8) + ALU_A_W'(HALF_MS);
          alu_b     = ALU_B_W'(DIV_MS);
          state_nxt = S_SLEW;
        end
      end
      S_SLEW: begin
        if (!alu_busy) begin
          if ($signed(chg) > $signed(step_v)) begin
            res_nxt = up_v[DRIVE_W-1:0];
          end else if ($signed(chg) < $signed(step_n)) begin
            res_nxt = dn_v[DRIVE_W-1:0];
          end else begin
            res_nxt = o_r;
          end
          last_drive_nxt = res_nxt;
          last_err_nxt   = err_r;
          state_nxt      = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_drive_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control, configuration and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      armed_r      <= 1'b0;
      integ_r      <= '0;
      last_err_r   <= '0;
      slope_r      <= '0;
      last_drive_r <= '0;
      out_valid_r  <= 1'b0;
      out_drive_r  <= '0;
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      olim_r       <= '0;
      slew_r       <= '0;
      ilim_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      armed_r      <= armed_nxt;
      integ_r      <= integ_nxt;
      last_err_r   <= last_err_nxt;
      slope_r      <= slope_nxt;
      last_drive_r <= last_drive_nxt;
      out_valid_r  <= out_valid_nxt;
      out_drive_r  <= out_drive_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN_P:    gain_p_r <= cfg_wdata[GAIN_W-1:0];
          CFG_GAIN_I:    gain_i_r <= cfg_wdata[GAIN_W-1:0];
          CFG_GAIN_D:    gain_d_r <= cfg_wdata[GAIN_W-1:0];
          CFG_OUT_LIMIT: olim_r   <= cfg_wdata[OLIM_W-1:0];
          CFG_SLEW:      slew_r   <= cfg_wdata[SLEW_W-1:0];
          CFG_INT_LIMIT: ilim_r   <= cfg_wdata[ILIM_W-1:0];
          default:       gain_p_r <= gain_p_r;
        endcase
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    dt_r    <= dt_nxt;
    err_r   <= err_nxt;
    p_mag_r <= p_mag_nxt;
    imag_r  <= imag_nxt;
    x_neg_r <= x_neg_nxt;
    sum_r   <= sum_nxt;
    o_r     <= o_nxt;
    res_r   <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

`ifndef NO_ASSERTIONS
  a_idle_alu_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !alu_busy)
    else $error("serial unit busy while sequencer idle");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    alu_cmd.start |-> !alu_busy)
    else $error("serial unit started while busy");

  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_restart |=> state_r == S_OUT && res_r == '0)
    else $error("restart item did not answer zero");

  a_armed_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE && state_r != S_OUT |-> armed_r)
    else $error("update computed while not armed");
`endif

endmodule

@@ tb/tb_pid_antiwindup_slew_limited_unit.sv @@
// ----------------------------------------------------------------------------
// tb_pid_antiwindup_slew_limited_unit: self-checking bench of the PID unit
// Drives a directed table and random items through valid/ready with random
// gaps and stalls, predicts each drive in the bench and compares in order.
// ----------------------------------------------------------------------------
module tb_pid_antiwindup_slew_limited_unit;
  import pidsl_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint unsigned ITERM_CAP = 64'd1 << ITERM_CAP_LG;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_wdata;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [POS_W-1:0]   in_setpoint;
  logic signed [POS_W-1:0]   in_measured;
  logic [DT_W-1:0]           in_elapsed_ms;
  logic                      in_restart;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [DRIVE_W-1:0] out_drive;

  pid_antiwindup_slew_limited_unit dut (.*);

  // controller model state and register copies
  longint gp, gi, gd, olim, slew, ilim;
  bit     armed;
  longint integ, prev_err, slope, prev_drive;

  logic signed [DRIVE_W-1:0] drive_q[$];
  int  errors = 0;
  bit  tx_quiet, rx_quiet;
  int  rx_stall = 0;
  int  rx_count = 0;
  int  rx_seen = 0;

  typedef struct {
    int sp;
    int ms;
    int dt;
    bit rs;
    bit chk;
    int drv;
  } row_t;

  row_t rows[12] = '{
    '{100, 0, 10, 0, 1, 0},            // first update arms only
    '{100, 0, 10, 0, 0, 0},
    '{32767, -32768, 65535, 0, 0, 0},  // largest positive error, longest dt
    '{-32768, 32767, 65535, 0, 0, 0},  // largest negative error
    '{0, 0, 0, 0, 0, 0},               // zero elapsed time
    '{50, 40, 1, 0, 0, 0},
    '{5, 5, 20, 1, 1, 0},              // restart answers zero
    '{-1000, 0, 5, 0, 0, 0},
    '{0, -32768, 0, 0, 0, 0},
    '{1, 0, 65535, 0, 0, 0},
    '{12, 3, 3, 1, 1, 0},
    '{12, 3, 3, 0, 0, 0}
  };

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic longint umag(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // round half away from zero
  function automatic longint rnd_div(longint num, longint den);
    longint q;
    q = (umag(num) + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [DRIVE_W-1:0] predict_drive(
      logic signed [POS_W-1:0] sp, logic signed [POS_W-1:0] ms,
      logic [DT_W-1:0] dt_in, bit rs);
    longint err, dt, p, inc, iterm, d, sum, o, stp, chg, raw, lim16, il, imax;
    longint unsigned m, q, r, im;
    dt = longint'(dt_in);
    imax = (longint'(1) <<< (INTEGRAL_BITS_DEF - 1)) - 1;
    lim16 = olim <<< 16;
    if (rs) begin
      integ = 0; prev_err = 0; slope = 0; prev_drive = 0; armed = 0;
    end
    if (!armed) begin
      armed = 1;
      return '0;
    end
    err = longint'(sp) - longint'(ms);
    p = gp * err;
    // integral with saturation, clamp and decay
    inc = rnd_div(err * dt * (longint'(1) <<< FRAC), 1000);
    if (inc > 0 && integ > imax - inc) integ = imax;
    else if (inc < 0 && integ < -imax - 1 - inc) integ = -imax - 1;
    else integ += inc;
    if (gi != 0) begin
      il = ilim <<< FRAC;
      if (integ > il) integ = il;
      else if (integ < -il) integ = -il;
      if (p > lim16 || p < -lim16) begin
        m = umag(integ);
        m -= (m + 5) / 10;
        integ = (integ < 0) ? -longint'(m) : longint'(m);
      end
    end
    m = umag(integ);
    q = m >> FRAC;
    r = m & ((64'd1 << FRAC) - 1);
    if (gi == 0) im = 0;
    else if (q > ITERM_CAP / longint'(gi)) im = ITERM_CAP;
    else begin
      im = gi * q + ((gi * r + (64'd1 << (FRAC - 1))) >> FRAC);
      if (im > ITERM_CAP) im = ITERM_CAP;
    end
    iterm = (integ < 0) ? -longint'(im) : longint'(im);
    // filtered derivative
    raw = 0;
    if (dt != 0) raw = rnd_div((err - prev_err) * 256000, dt);
    slope = rnd_div(4 * raw + slope, 5);
    d = rnd_div(gd * slope, 256);
    sum = p + iterm + d;
    if (sum > lim16) sum = lim16;
    else if (sum < -lim16) sum = -lim16;
    o = rnd_div(sum, 256);
    // slew limit
    stp = (slew * dt * 256 + 500) / 1000;
    chg = o - prev_drive;
    if (chg > stp) o = prev_drive + stp;
    else if (chg < -stp) o = prev_drive - stp;
    prev_drive = o;
    prev_err = err;
    return o[DRIVE_W-1:0];
  endfunction

  // one register write; called and returns at a falling edge
  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    case (idx)
      CFG_GAIN_P:    gp = val & 24'hFFFFFF;
      CFG_GAIN_I:    gi = val & 24'hFFFFFF;
      CFG_GAIN_D:    gd = val & 24'hFFFFFF;
      CFG_OUT_LIMIT: olim = val & 15'h7FFF;
      CFG_SLEW:      slew = val & 16'hFFFF;
      CFG_INT_LIMIT: ilim = val & 31'h7FFFFFFF;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(longint p, longint i, longint d, longint ol, longint sl,
                          longint il);
    reg_write(CFG_GAIN_P, p);
    reg_write(CFG_GAIN_I, i);
    reg_write(CFG_GAIN_D, d);
    reg_write(CFG_OUT_LIMIT, ol);
    reg_write(CFG_SLEW, sl);
    reg_write(CFG_INT_LIMIT, il);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending and wait until every expected drive has come
  task automatic drain;
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // present one item, wait for acceptance, then optional gap
  task automatic send_item(int sp, int ms, int dt, bit rs, bit chk, int drv);
    logic signed [DRIVE_W-1:0] pred;
    int gap;
    in_valid <= 1'b1;
    in_setpoint <= sp[POS_W-1:0];
    in_measured <= ms[POS_W-1:0];
    in_elapsed_ms <= dt[DT_W-1:0];
    in_restart <= rs;
    do @(posedge clk); while (!in_ready);
    pred = predict_drive(sp[POS_W-1:0], ms[POS_W-1:0], dt[DT_W-1:0], rs);
    drive_q.push_back(chk ? drv[DRIVE_W-1:0] : pred);
    @(negedge clk);
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // receiver stalls: a fresh wait is drawn after every accepted drive
  always @(negedge clk) begin
    if (rx_count != rx_seen) begin
      rx_seen = rx_count;
      rx_stall = rx_quiet ? 0 : $urandom_range(0, 14);
    end
    if (rx_stall > 0) begin
      rx_stall = rx_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (drive_q.size() == 0) begin
        $display("%0t unexpected drive: expected none, got %0d", $time, out_drive);
        errors++;
      end else begin
        if (out_drive !== drive_q[0]) begin
          $display("%0t drive mismatch: expected %0d, got %0d", $time, drive_q[0],
                   out_drive);
          errors++;
        end
        void'(drive_q.pop_front());
      end
      rx_count++;
    end
  end

  // stimulus
  initial begin
    int sp, ms, dt, kind;
    rst_n = 0;
    cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 0; in_setpoint = '0; in_measured = '0;
    in_elapsed_ms = '0; in_restart = 0;
    tx_quiet = 0; rx_quiet = 0;
    gp = 0; gi = 0; gd = 0; olim = 0; slew = 0; ilim = 0;
    armed = 0; integ = 0; prev_err = 0; slope = 0; prev_drive = 0;
    repeat (6) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed table
    set_regs(65536, 32768, 16384, 1000, 5000, 2000);
    reg_write(3'd6, 123);  // unused index, ignored
    cfg_we <= 1'b0;
    @(negedge clk);
    foreach (rows[k])
      send_item(rows[k].sp, rows[k].ms, rows[k].dt, rows[k].rs, rows[k].chk,
                rows[k].drv);
    drain();

    // random phases with differing settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32767, 65535, 31'h7FFFFFFF);
        1: set_regs($urandom_range(0, 300000), 0, $urandom_range(0, 5000),
                    $urandom_range(100, 32767), $urandom_range(0, 65535), 0);
        2: set_regs(0, 0, 0, 0, 0, 0);
        default: set_regs($urandom_range(0, 400000), $urandom_range(1, 100000),
                          $urandom_range(0, 20000), $urandom_range(0, 32767),
                          $urandom_range(0, 65535), $urandom_range(0, 100000));
      endcase
      tx_quiet = (ph == 4);
      rx_quiet = (ph == 4);
      for (int n = 0; n < 90; n++) begin
        kind = $urandom_range(0, 9);
        sp = $signed(16'($urandom));
        ms = (kind < 6) ? sp + $signed(12'($urandom)) : $signed(16'($urandom));
        if (ms > 32767) ms = 32767;
        if (ms < -32768) ms = -32768;
        case ($urandom_range(0, 9))
          0: dt = 0;
          1: dt = 65535;
          2: dt = $urandom_range(0, 65535);
          default: dt = $urandom_range(1, 50);
        endcase
        send_item(sp, ms, dt, $urandom_range(0, 19) == 0, 0, 0);
        if (n == 45) drain();
      end
      drain();
    end

    drain();
    repeat (500) @(negedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pidsl_pkg.sv
rtl/pidsl_serial_alu.sv
rtl/pid_antiwindup_slew_limited_unit.sv
tb/tb_pid_antiwindup_slew_limited_unit.sv
